@@ design/largest_gap_midpoint_allocator_assert.svh @@
// Assertion macros for the largest-gap midpoint allocator.
`ifndef LARGEST_GAP_MIDPOINT_ALLOCATOR_ASSERT_SVH
`define LARGEST_GAP_MIDPOINT_ALLOCATOR_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on the rising clock edge.
`define LGMA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define LGMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`else

`define LGMA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LGMA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ design/lgma_pkg.sv @@
// Shared constants and controller/datapath types for the midpoint allocator.
package lgma_pkg;

	// Fixed field widths.
	localparam int SLOT_W = 6;
	localparam int GAP_W  = 7;
	localparam int CFG_W  = 7;

	// Default slot count and reset value of the slots-in-use register.
	localparam int          MAX_SLOTS_DEF = 64;
	localparam logic [CFG_W-1:0] SLOTS_RESET = 7'd64;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // take a new request, reset the scan
		logic scan;    // read (and clear if needed) one slot, advance
		logic finish;  // mark the midpoint and load the result register
	} lgma_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_last;  // the current scan address is the last slot
		logic out_free;   // result register can take a new result
	} lgma_sts_t;

endpackage

@@ design/lgma_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lgma_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/lgma_ctrl.sv @@
// Controller state machine that sequences the slot scan for each request.
module lgma_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  lgma_pkg::lgma_sts_t   sts,
	output lgma_pkg::lgma_cmd_t   cmd
);

	import lgma_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t state_q;

	// The input side is open only while no request is in progress.
	assign in_stall = (state_q != ST_IDLE);

	// Command decode from the current state.
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:   cmd.load   = in_valid;
			ST_SCAN:   cmd.scan   = 1'b1;
			ST_DRAIN:  cmd        = '0;
			ST_FINISH: cmd.finish = sts.out_free;
			default:   cmd        = '0;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/lgma_dp.sv @@
// Datapath: occupancy memory, run tracking, midpoint and result register.
module lgma_dp #(
	parameter int MAX_SLOTS = lgma_pkg::MAX_SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lgma_pkg::lgma_cmd_t         cmd,
	output lgma_pkg::lgma_sts_t         sts,
	input  logic                        start_new,
	input  logic                        cfg_we,
	input  logic [lgma_pkg::CFG_W-1:0]  cfg_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [lgma_pkg::SLOT_W-1:0] slot_taken,
	output logic [lgma_pkg::GAP_W-1:0]  gap_length,
	output logic                        all_full
);

	import lgma_pkg::*;

	localparam int PW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int NW = $clog2(MAX_SLOTS + 1);
	localparam logic [PW-1:0] LAST_POS = PW'(MAX_SLOTS - 1);

	logic [CFG_W-1:0]  cfg_q;
	logic              clr_pend_q;
	logic              clr_q;
	logic [PW-1:0]     addr_q;
	logic              vld_s1;
	logic [PW-1:0]     pos_s1;
	logic [NW-1:0]     run_q;
	logic [NW-1:0]     best_q;
	logic [PW-1:0]     best_end_q;
	logic [NW-1:0]     n_lim;
	logic [NW-1:0]     run_next;
	logic              in_range;
	logic              occ;
	logic              found;
	logic [PW:0]       mid_sum;
	logic [PW-1:0]     mid;
	logic              ram_we;
	logic [PW-1:0]     ram_waddr;
	logic [0:0]        ram_rdata;
	logic              out_valid_q;

	// Slots-in-use register; the write channel is always ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= SLOTS_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_data;
		end
	end

	// Effective slot count, saturated to the map size.
	assign n_lim = (int'(cfg_q) > MAX_SLOTS) ? NW'(MAX_SLOTS) : NW'(cfg_q);

	// After reset the memory content is unknown, so the first request clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_pend_q <= 1'b1;
			clr_q      <= 1'b0;
		end else if (cmd.load) begin
			clr_pend_q <= 1'b0;
			clr_q      <= start_new | clr_pend_q;
		end
	end

	// Scan address counter, one slot per cycle over the whole map.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (cmd.load) begin
			addr_q <= '0;
		end else if (cmd.scan) begin
			addr_q <= PW'(addr_q + 1'b1);
		end
	end

	assign sts.scan_last = (addr_q == LAST_POS);
	assign sts.out_free  = !out_valid_q || !out_stall;

	// Midpoint of the best run: (first + end) / 2 with first = end + 1 - best.
	assign found   = (best_q != '0);
	assign mid_sum = (PW + 1)'({best_end_q, 1'b1}) - (PW + 1)'(best_q);
	assign mid     = mid_sum[PW:1];

	// Memory writes: clearing during a batch-start scan, marking at the end.
	assign ram_we    = (cmd.scan && clr_q) || (cmd.finish && found);
	assign ram_waddr = cmd.finish ? mid : addr_q;

	lgma_ram #(
		.WIDTH (1),
		.DEPTH (MAX_SLOTS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (cmd.finish),
		.re    (cmd.scan),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	// Read data stage: position and valid follow the registered read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan;
		end
	end

	always_ff @(posedge clk) begin
		pos_s1 <= addr_q;
	end

	// Run tracking; on equal lengths the later run wins.
	assign in_range = (NW'(pos_s1) < n_lim);
	assign occ      = !clr_q && ram_rdata[0];
	assign run_next = NW'(run_q + 1'b1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			run_q      <= '0;
			best_q     <= '0;
			best_end_q <= '0;
		end else if (vld_s1 && in_range) begin
			if (occ) begin
				run_q <= '0;
			end else begin
				run_q <= run_next;
				if (run_next >= best_q) begin
					best_q     <= run_next;
					best_end_q <= pos_s1;
				end
			end
		end
	end

	// Result register; a transfer frees it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			slot_taken <= found ? SLOT_W'(mid) : '0;
			gap_length <= GAP_W'(best_q);
			all_full   <= !found;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ design/largest_gap_midpoint_allocator.sv @@
// Top level of the largest-gap midpoint slot allocator.
//
//   Channel   Handshake                 Payload
//   input     in_valid / in_stall       start_new
//   output    out_valid / out_stall     slot_taken, gap_length, all_full
//   config    cfg_valid / cfg_ready     slots_in_use
//
// After its transfer, a request scans the occupancy memory one slot per cycle
// over the whole map, then drains the read stage and marks the midpoint.
// Reset is asynchronous; the first request after reset clears the map
// while it scans, so no separate clearing pass runs.
// A stalled result waits in its register while the next request scans.
module largest_gap_midpoint_allocator #(
	parameter int MAX_SLOTS = lgma_pkg::MAX_SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        start_new,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [lgma_pkg::SLOT_W-1:0] slot_taken,
	output logic [lgma_pkg::GAP_W-1:0]  gap_length,
	output logic                        all_full,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lgma_pkg::CFG_W-1:0]  slots_in_use
);

	import lgma_pkg::*;

`include "largest_gap_midpoint_allocator_assert.svh"

	lgma_cmd_t cmd;
	lgma_sts_t sts;

	// The single register is always writable.
	assign cfg_ready = 1'b1;

	lgma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lgma_dp #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.start_new  (start_new),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (slots_in_use),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.slot_taken (slot_taken),
		.gap_length (gap_length),
		.all_full   (all_full)
	);

	// An accepted request keeps the input closed in the next cycle.
	`LGMA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

	// A full answer carries no slot and no run length.
	`LGMA_ASSERT_SAME(a_full_payload, clk, arst_n, out_valid && all_full, slot_taken == '0 && gap_length == '0)

	// A placement always comes from a nonempty run.
	`LGMA_ASSERT_SAME(a_gap_nonzero, clk, arst_n, out_valid && !all_full, gap_length != '0)

	// A finish command only issues when the result register is free.
	`LGMA_ASSERT_SAME(a_finish_free, clk, arst_n, cmd.finish, !out_valid || !out_stall)

endmodule

@@ test/allocation_checker.sv @@
// Checker for the midpoint allocator: predicts each allocation and compares it.
module allocation_checker #(
	parameter int MAX_SLOTS = lgma_pkg::MAX_SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic                        start_new,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [lgma_pkg::SLOT_W-1:0] slot_taken,
	input  logic [lgma_pkg::GAP_W-1:0]  gap_length,
	input  logic                        all_full,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [lgma_pkg::CFG_W-1:0]  slots_in_use,
	input  logic                        final_check,
	output int                          pending,
	output int                          errors
);
	import lgma_pkg::*;

	// One predicted allocation.
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [GAP_W-1:0]  gap;
		logic              full;
	} alloc_t;

	// Predictor state: the occupancy map and the slot count register.
	logic [MAX_SLOTS-1:0] taken_slots;
	logic [CFG_W-1:0]     slot_count;
	alloc_t               expected_allocs[$];

	// Prints one line per mismatch and counts it.
	task automatic report(input string what, input int got, input int want);
		$display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	// Finds the longest free run (later run wins a tie), takes its middle slot.
	function automatic alloc_t allocate_slot(input logic clear);
		int     limit;
		int     run;
		int     best;
		int     best_end;
		int     mid;
		alloc_t res;
		limit = (int'(slot_count) > MAX_SLOTS) ? MAX_SLOTS : int'(slot_count);
		if (clear)
			taken_slots = '0;
		run = 0;
		best = 0;
		best_end = 0;
		for (int p = 0; p < limit; p++) begin
			if (taken_slots[p]) begin
				run = 0;
			end else begin
				run++;
				if (run >= best) begin
					best = run;
					best_end = p;
				end
			end
		end
		if (best == 0) begin
			res.slot = '0;
			res.gap = '0;
			res.full = 1'b1;
		end else begin
			mid = (best_end + 1 - best + best_end) / 2;
			taken_slots[mid] = 1'b1;
			res.slot = mid[SLOT_W-1:0];
			res.gap = best[GAP_W-1:0];
			res.full = 1'b0;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_t want;
		if (!arst_n) begin
			taken_slots = '0;
			slot_count = SLOTS_RESET;
			expected_allocs.delete();
			pending <= 0;
		end else begin
			// Register write.
			if (cfg_valid && cfg_ready)
				slot_count = slots_in_use;

			// Result transfer: compare with the oldest prediction.
			if (out_valid && !out_stall) begin
				if (expected_allocs.size() == 0) begin
					report("result with nothing expected", int'(slot_taken), 0);
				end else begin
					want = expected_allocs.pop_front();
					if (slot_taken !== want.slot)
						report("slot_taken", int'(slot_taken), int'(want.slot));
					if (gap_length !== want.gap)
						report("gap_length", int'(gap_length), int'(want.gap));
					if (all_full !== want.full)
						report("all_full", int'(all_full), int'(want.full));
				end
			end

			// Request transfer: predict its result.
			if (in_valid && !in_stall)
				expected_allocs.push_back(allocate_slot(start_new));

			// Anything still waiting at the end is a missing result.
			if (final_check && expected_allocs.size() != 0)
				report("results missing at end", expected_allocs.size(), 0);

			pending <= expected_allocs.size();
		end
	end

endmodule

@@ test/tb_top.sv @@
// Testbench top for the midpoint allocator: stimulus, stall patterns and verdict.
module tb_top;
	import lgma_pkg::*;

	localparam int IDLE_LIMIT   = 4000;
	localparam int RANDOM_ITEMS = 450;

	// Receiver stall patterns.
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_COIN,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              start_new = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [SLOT_W-1:0] slot_taken;
	logic [GAP_W-1:0]  gap_length;
	logic              all_full;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_W-1:0]  slots_in_use = SLOTS_RESET;
	logic              final_check = 1'b0;
	int                pending;
	int                errors;

	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;
	int          idle_cycles = 0;
	int          burst_left = 1;
	int          sent = 0;

	always #4 clk = ~clk;

	largest_gap_midpoint_allocator DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .start_new(start_new),
		.out_valid(out_valid), .out_stall(out_stall),
		.slot_taken(slot_taken), .gap_length(gap_length), .all_full(all_full),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .slots_in_use(slots_in_use)
	);

	allocation_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .start_new(start_new),
		.out_valid(out_valid), .out_stall(out_stall),
		.slot_taken(slot_taken), .gap_length(gap_length), .all_full(all_full),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .slots_in_use(slots_in_use),
		.final_check(final_check), .pending(pending), .errors(errors)
	);

	// The receiver switches between stall patterns, holding each for a random time.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (stall_left == 0) begin
				stall_mode <= stall_mode_t'($urandom_range(0, 3));
				stall_left <= $urandom_range(50, 300);
			end else begin
				stall_left <= stall_left - 1;
			end
			case (stall_mode)
				STALL_NONE:     out_stall <= 1'b0;
				STALL_COIN:     out_stall <= 1'($urandom_range(0, 1));
				STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
				STALL_PERIODIC: out_stall <= ((stall_left % 32) < 12);
			endcase
		end
	end

	// Watchdog: ends the run when no transfer happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("largest_gap_midpoint_allocator verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Sends one request; the sender works in bursts with random gaps between.
	task automatic send_request(input logic clear);
		in_valid <= 1'b1;
		start_new <= clear;
		do @(posedge clk); while (in_stall);
		sent++;
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 6);
		end
	endtask

	// Writes the slot count once every outstanding result has arrived.
	task automatic set_slot_count(input int count);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_valid <= 1'b1;
		slots_in_use <= count[CFG_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int count;
		int items;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full map: a fresh batch, then ties between equal runs.
		send_request(1'b1);
		repeat (5) send_request(1'b0);

		// A single slot: take it, then full twice.
		set_slot_count(1);
		send_request(1'b1);
		send_request(1'b0);
		send_request(1'b0);

		// No slots in use answers full, even right after clearing.
		set_slot_count(0);
		send_request(1'b0);
		send_request(1'b1);

		// A count above the map size saturates to the whole map.
		set_slot_count(127);
		send_request(1'b0);
		send_request(1'b1);
		send_request(1'b0);

		// Three slots: fill them, then full.
		set_slot_count(3);
		send_request(1'b1);
		repeat (3) send_request(1'b0);

		// Random phases: mostly batches that fill up, some clears mid batch.
		while (sent < RANDOM_ITEMS - 20) begin
			case ($urandom_range(0, 9))
				0:       count = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(65, 127);
				1:       count = MAX_SLOTS_DEF;
				2, 3, 4, 5: count = $urandom_range(1, 8);
				default: count = $urandom_range(9, 63);
			endcase
			set_slot_count(count);
			items = $urandom_range(5, 40);
			send_request($urandom_range(0, 3) != 0);
			repeat (items - 1) send_request($urandom_range(0, 19) == 0);
		end

		// Drain, then check for leftovers and give the verdict.
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		final_check <= 1'b1;
		@(posedge clk);
		final_check <= 1'b0;
		@(posedge clk);
		if (errors == 0) begin
			$display("largest_gap_midpoint_allocator verification clean");
		end else begin
			$display("largest_gap_midpoint_allocator verification failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+design
design/lgma_pkg.sv
design/lgma_ram.sv
design/lgma_ctrl.sv
design/lgma_dp.sv
design/largest_gap_midpoint_allocator.sv
test/allocation_checker.sv
test/tb_top.sv
